[rtl/gkdr_pkg.sv]
// ----------------------------------------------------------------------------
// gkdr_pkg
// Types, codes and helper functions shared by the key debounce and repeat core.
// ----------------------------------------------------------------------------
package gkdr_pkg;

   localparam int unsigned PINS_MAX   = 32;
   localparam int unsigned TIME_W     = 9;
   localparam int unsigned DELAY_W    = 8;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_PIN_MASK       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IRQ_LINES      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_MASK    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_ALL     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_RELEASE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_PRESS    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_RELEASE = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_PRESS   = 3'd7;

   localparam logic [DELAY_W-1:0] FIRST_RELEASE_RST  = 8'd80;
   localparam logic [DELAY_W-1:0] FIRST_PRESS_RST    = 8'd200;
   localparam logic [DELAY_W-1:0] REPEAT_RELEASE_RST = 8'd40;
   localparam logic [DELAY_W-1:0] REPEAT_PRESS_RST   = 8'd40;

   typedef enum logic [2:0] {
      PH_FIRST_RELEASE  = 3'd0,
      PH_FIRST_PRESS    = 3'd1,
      PH_REPEAT_RELEASE = 3'd2,
      PH_REPEAT_PRESS   = 3'd3,
      PH_IDLE           = 3'd4
   } phase_type;

   typedef struct packed {
      logic [PINS_MAX-1:0]          pin_mask;
      logic [PINS_MAX-1:0]          irq_lines;
      logic [PINS_MAX-1:0]          repeat_mask;
      logic                         repeat_all;
      logic [3:0][DELAY_W-1:0]      delay;
   } cfg_type;

   typedef struct packed {
      logic [PINS_MAX-1:0] press;
      logic [PINS_MAX-1:0] xio;
      logic [PINS_MAX-1:0] held;
   } settle_out_type;

   function automatic phase_type phase_next(input phase_type ph);
      phase_type nxt;
      case (ph)
         PH_FIRST_RELEASE:  nxt = PH_FIRST_PRESS;
         PH_FIRST_PRESS:    nxt = PH_REPEAT_RELEASE;
         PH_REPEAT_RELEASE: nxt = PH_REPEAT_PRESS;
         PH_REPEAT_PRESS:   nxt = PH_REPEAT_RELEASE;
         default:           nxt = PH_FIRST_PRESS;
      endcase
      return nxt;
   endfunction

   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
   endfunction

endpackage

[rtl/gpio_key_debounce_repeat_core.sv]
// ----------------------------------------------------------------------------
// gpio_key_debounce_repeat_core
// Debounced key group with press, interrupt and auto repeat events per tick.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake             Payload
// req      in   req_tvalid/tready     pin_levels
// rsp      out  rsp_tvalid/tready     press_events, xio_events, repeat_events
// csr      in   csr_we                csr_index, csr_wdata
//
// One request is taken per cycle; its result appears in the output register
// the cycle after acceptance. All pin lanes update in the same cycle, so the
// rate is set by the single output register: a new request is taken whenever
// that register is empty or is being emptied. Reset is synchronous and
// restores every register and timer at once, except the output data.
// ----------------------------------------------------------------------------
module gpio_key_debounce_repeat_core #(
   parameter int unsigned PIN_COUNT    = 32,
   parameter int unsigned SETTLE_TICKS = 2,
   parameter int unsigned TICK_MS      = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [31:0]                        req_tdata,  // pin_levels
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [95:0]                        rsp_tdata,  // press, xio, repeat events
   input  logic                               csr_we,
   input  logic [gkdr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                        csr_wdata
);

   localparam logic [gkdr_pkg::PINS_MAX-1:0] LANES =
      gkdr_pkg::PINS_MAX'((64'd1 << PIN_COUNT) - 64'd1);

   gkdr_pkg::cfg_type              cfg_ff;
   gkdr_pkg::settle_out_type       settle;
   logic [gkdr_pkg::PINS_MAX-1:0]  sample, repeat_hits;
   logic [95:0]                    data_ff;
   logic                           valid_ff, step;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pin_mask     <= '0;
         cfg_ff.irq_lines    <= '0;
         cfg_ff.repeat_mask  <= '0;
         cfg_ff.repeat_all   <= 1'b0;
         cfg_ff.delay[0]     <= gkdr_pkg::FIRST_RELEASE_RST;
         cfg_ff.delay[1]     <= gkdr_pkg::FIRST_PRESS_RST;
         cfg_ff.delay[2]     <= gkdr_pkg::REPEAT_RELEASE_RST;
         cfg_ff.delay[3]     <= gkdr_pkg::REPEAT_PRESS_RST;
      end else if (csr_we) begin
         case (csr_index)
            gkdr_pkg::CSR_PIN_MASK:       cfg_ff.pin_mask     <= csr_wdata;
            gkdr_pkg::CSR_IRQ_LINES:      cfg_ff.irq_lines    <= csr_wdata;
            gkdr_pkg::CSR_REPEAT_MASK:    cfg_ff.repeat_mask  <= csr_wdata;
            gkdr_pkg::CSR_REPEAT_ALL:     cfg_ff.repeat_all   <= csr_wdata[0];
            gkdr_pkg::CSR_FIRST_RELEASE:  cfg_ff.delay[0]     <= csr_wdata[7:0];
            gkdr_pkg::CSR_FIRST_PRESS:    cfg_ff.delay[1]     <= csr_wdata[7:0];
            gkdr_pkg::CSR_REPEAT_RELEASE: cfg_ff.delay[2]     <= csr_wdata[7:0];
            gkdr_pkg::CSR_REPEAT_PRESS:   cfg_ff.delay[3]     <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign req_tready = !valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;
   assign sample     = req_tdata & cfg_ff.pin_mask & LANES;

   gkdr_settle #(
      .PIN_COUNT    (PIN_COUNT),
      .SETTLE_TICKS (SETTLE_TICKS)
   ) u_settle (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .sample    (sample),
      .pin_mask  (cfg_ff.pin_mask),
      .irq_lines (cfg_ff.irq_lines),
      .result    (settle)
   );

   for (genvar i = 0; i < gkdr_pkg::PINS_MAX; i++) begin : g_lane
      if (i < PIN_COUNT) begin : g_on
         gkdr_lane #(
            .TICK_MS (TICK_MS)
         ) u_lane (
            .clock      (clock),
            .reset      (reset),
            .step       (step),
            .enable     (cfg_ff.repeat_mask[i] || cfg_ff.repeat_all),
            .held       (settle.held[i]),
            .delay      (cfg_ff.delay),
            .repeat_hit (repeat_hits[i])
         );
      end else begin : g_off
         assign repeat_hits[i] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (step) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         data_ff <= {repeat_hits & LANES, settle.xio, settle.press};
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

[rtl/gkdr_settle.sv]
// ----------------------------------------------------------------------------
// gkdr_settle
// Shared debounce state: change tracking, settle counter and held detection.
// ----------------------------------------------------------------------------
module gkdr_settle #(
   parameter int unsigned PIN_COUNT    = 32,
   parameter int unsigned SETTLE_TICKS = 2
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic [gkdr_pkg::PINS_MAX-1:0]   sample,
   input  logic [gkdr_pkg::PINS_MAX-1:0]   pin_mask,
   input  logic [gkdr_pkg::PINS_MAX-1:0]   irq_lines,
   output gkdr_pkg::settle_out_type        result
);

   localparam int unsigned CNT_W = $clog2(SETTLE_TICKS + 1);
   localparam logic [CNT_W-1:0] SETTLE = CNT_W'(SETTLE_TICKS);
   localparam logic [gkdr_pkg::PINS_MAX-1:0] LANES =
      gkdr_pkg::PINS_MAX'((64'd1 << PIN_COUNT) - 64'd1);

   logic [gkdr_pkg::PINS_MAX-1:0] last_ff, last_in;
   logic [gkdr_pkg::PINS_MAX-1:0] pend_ff, pend_in;
   logic [gkdr_pkg::PINS_MAX-1:0] held_prev_ff, held_prev_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;

   logic [gkdr_pkg::PINS_MAX-1:0] pend_now, low;
   logic [CNT_W-1:0]              cnt_now;
   logic                          settled;

   always_comb begin
      cnt_now  = (sample != last_ff) ? '0 : cnt_ff;
      pend_now = pend_ff | (sample ^ last_ff);
      settled  = cnt_now >= SETTLE;
      low      = ~sample & pin_mask & LANES;

      result.press = settled ? (pend_now & ~sample & LANES) : '0;
      result.xio   = settled ? (~sample & irq_lines & LANES) : '0;
      result.held  = low & held_prev_ff;

      last_in      = sample;
      pend_in      = settled ? '0 : pend_now;
      cnt_in       = (cnt_now < SETTLE) ? cnt_now + CNT_W'(1) : cnt_now;
      held_prev_in = low;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff      <= '0;
         pend_ff      <= '0;
         held_prev_ff <= '0;
         cnt_ff       <= '0;
      end else if (step) begin
         last_ff      <= last_in;
         pend_ff      <= pend_in;
         held_prev_ff <= held_prev_in;
         cnt_ff       <= cnt_in;
      end
   end

endmodule

[rtl/gkdr_lane.sv]
// ----------------------------------------------------------------------------
// gkdr_lane
// Auto repeat timer of one pin: four-phase delay table with saturating times.
// ----------------------------------------------------------------------------
module gkdr_lane #(
   parameter int unsigned TICK_MS = 4
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          step,
   input  logic                                          enable,
   input  logic                                          held,
   input  logic [3:0][gkdr_pkg::DELAY_W-1:0]             delay,
   output logic                                          repeat_hit
);

   localparam logic [gkdr_pkg::TIME_W-1:0] TICK = gkdr_pkg::TIME_W'(TICK_MS);

   gkdr_pkg::phase_type               phase_ff, phase_in, nxt;
   logic [gkdr_pkg::TIME_W-1:0]       elapsed_ff, elapsed_in;
   logic [gkdr_pkg::TIME_W-1:0]       deadline_ff, deadline_in;
   logic [gkdr_pkg::TIME_W-1:0]       grown;

   always_comb begin
      grown       = gkdr_pkg::sat_add(elapsed_ff, TICK);
      nxt         = gkdr_pkg::phase_next(phase_ff);
      phase_in    = phase_ff;
      elapsed_in  = elapsed_ff;
      deadline_in = deadline_ff;
      repeat_hit  = 1'b0;
      if (enable) begin
         if (held) begin
            if (phase_ff == gkdr_pkg::PH_IDLE) begin
               phase_in    = gkdr_pkg::PH_FIRST_RELEASE;
               deadline_in = gkdr_pkg::sat_add(grown, {1'b0, delay[0]});
               elapsed_in  = '0;
            end else if (grown >= deadline_ff) begin
               repeat_hit  = 1'b1;
               phase_in    = nxt;
               deadline_in = {1'b0, delay[nxt[1:0]]};
               elapsed_in  = '0;
            end else begin
               elapsed_in  = grown;
            end
         end else begin
            phase_in    = gkdr_pkg::PH_IDLE;
            elapsed_in  = '0;
            deadline_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= gkdr_pkg::PH_IDLE;
         elapsed_ff  <= '0;
         deadline_ff <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         elapsed_ff  <= elapsed_in;
         deadline_ff <= deadline_in;
      end
   end

endmodule
